// ----- hw/rtl/bsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg - shared definitions for the six-step hall commutator
// Widths, register codes, reset values, duty scaling constants, the hall
// to sector table and the structs passed between the commutator modules.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // field widths
   localparam int THROTTLE_W  = 12;
   localparam int DUTY_W      = 13;
   localparam int SECTOR_W    = 3;
   localparam int HALL_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // PWM timer and throttle scaling
   localparam int PWM_PERIOD          = 5000;
   localparam int THROTTLE_FULL_SCALE = 2300;
   localparam int DUTY_PERCENT        = 94;
   localparam int PERCENT_BASE        = 100;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_STEP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_CEILING  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUAL_SECTOR = 3'd3;

   // register and state reset values
   localparam logic [THROTTLE_W-1:0] DEADBAND_RST      = 12'd600;
   localparam logic [DUTY_W-1:0]     SLEW_STEP_RST     = 13'd20;
   localparam logic [DUTY_W-1:0]     DUTY_CEILING_RST  = 13'd4800;
   localparam logic [DUTY_W-1:0]     HELD_DUTY_RST     = 13'd500;

   // sector codes
   localparam logic [SECTOR_W-1:0] SECTOR_OFF       = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_A_HI_B_LO = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_A_HI_C_LO = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_B_HI_C_LO = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_B_HI_A_LO = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_C_HI_A_LO = 3'd5;
   localparam logic [SECTOR_W-1:0] SECTOR_C_HI_B_LO = 3'd6;
   localparam logic [SECTOR_W-1:0] SECTOR_FROM_HALL = 3'd7;
   localparam logic [SECTOR_W-1:0] MANUAL_SECTOR_RST = SECTOR_FROM_HALL;

   // hall code {u,v,w} to sector
   localparam logic [SECTOR_W-1:0] HALL_SECTOR_TABLE [0:7] = '{
      SECTOR_OFF,       SECTOR_A_HI_C_LO, SECTOR_B_HI_A_LO, SECTOR_B_HI_C_LO,
      SECTOR_C_HI_B_LO, SECTOR_A_HI_B_LO, SECTOR_C_HI_A_LO, SECTOR_OFF
   };

   // greatest common divisor by repeated subtraction, elaboration only
   function automatic longint unsigned gcd_const(input longint unsigned a,
                                                 input longint unsigned b);
      longint unsigned x;
      longint unsigned y;
      x = a;
      y = b;
      while (x != y) begin
         if (x > y) begin
            x = x - y;
         end else begin
            y = y - x;
         end
      end
      return x;
   endfunction

   // target = floor(t * NUM / DEN) done as (t * SCALE_MULT) >> SCALE_SHIFT;
   // the extra shift bit keeps the rounding error below 1/DEN for 12-bit t
   localparam longint unsigned DUTY_NUM   = longint'(PWM_PERIOD) * DUTY_PERCENT;
   localparam longint unsigned DUTY_DEN   = longint'(THROTTLE_FULL_SCALE) * PERCENT_BASE;
   localparam longint unsigned DUTY_GCD   = gcd_const(DUTY_NUM, DUTY_DEN);
   localparam longint unsigned SCALE_NUM  = DUTY_NUM / DUTY_GCD;
   localparam longint unsigned SCALE_DEN  = DUTY_DEN / DUTY_GCD;
   localparam int              SCALE_SHIFT = THROTTLE_W + $clog2(SCALE_DEN) + 1;
   localparam longint unsigned SCALE_MULT =
      ((SCALE_NUM << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
   localparam int              SCALE_MULT_W = $clog2(SCALE_MULT + 1);
   localparam int              PRODUCT_W    = THROTTLE_W + SCALE_MULT_W;

   localparam logic [THROTTLE_W-1:0] FULL_SCALE_CODE = THROTTLE_W'(THROTTLE_FULL_SCALE);

   // item in the middle stage
   typedef struct packed {
      logic [DUTY_W-1:0]   target;
      logic [SECTOR_W-1:0] sector;
      logic                motor_disable;
   } mid_type;

   // gate drive pattern of one result item
   typedef struct packed {
      logic                high_pwm_a;
      logic                high_pwm_b;
      logic                high_pwm_c;
      logic                low_on_a;
      logic                low_on_b;
      logic                low_on_c;
      logic [SECTOR_W-1:0] sector_used;
      logic                sector_fault;
   } drive_type;

endpackage

// ----- hw/rtl/bsc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_req_if - control tick channel
// Valid/ready channel carrying one throttle sample, hall levels and disable.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsc_pkg::THROTTLE_W-1:0] throttle;
   logic                          hall_u;
   logic                          hall_v;
   logic                          hall_w;
   logic                          motor_disable;

   modport source (
      output valid, throttle, hall_u, hall_v, hall_w, motor_disable,
      input  ready
   );
   modport sink (
      input  valid, throttle, hall_u, hall_v, hall_w, motor_disable,
      output ready
   );
endinterface

// ----- hw/rtl/bsc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_rsp_if - gate drive result channel
// Valid/ready channel carrying duty, phase drive bits and sector status.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsc_pkg::DUTY_W-1:0]    duty;
   logic                          high_pwm_a;
   logic                          high_pwm_b;
   logic                          high_pwm_c;
   logic                          low_on_a;
   logic                          low_on_b;
   logic                          low_on_c;
   logic [bsc_pkg::SECTOR_W-1:0]  sector_used;
   logic                          sector_fault;

   modport source (
      output valid, duty, high_pwm_a, high_pwm_b, high_pwm_c,
             low_on_a, low_on_b, low_on_c, sector_used, sector_fault,
      input  ready
   );
   modport sink (
      input  valid, duty, high_pwm_a, high_pwm_b, high_pwm_c,
             low_on_a, low_on_b, low_on_c, sector_used, sector_fault,
      output ready
   );
endinterface

// ----- hw/rtl/bsc_duty_target.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_duty_target - throttle to target duty
// Deadband, full-scale clamp, constant reciprocal scaling and ceiling clamp.
// ----------------------------------------------------------------------------
module bsc_duty_target (
   input  logic [bsc_pkg::THROTTLE_W-1:0] throttle,
   input  logic [bsc_pkg::THROTTLE_W-1:0] deadband,
   input  logic [bsc_pkg::DUTY_W-1:0]     ceiling,
   output logic [bsc_pkg::DUTY_W-1:0]     target
);

   logic [bsc_pkg::THROTTLE_W-1:0] thr_gated;
   logic [bsc_pkg::THROTTLE_W-1:0] thr_clamped;
   logic [bsc_pkg::PRODUCT_W-1:0]  product;
   logic [bsc_pkg::PRODUCT_W-1:0]  quotient;
   logic [bsc_pkg::DUTY_W-1:0]     scaled;

   // deadband and full-scale clamp
   assign thr_gated   = (throttle < deadband) ? '0 : throttle;
   assign thr_clamped = (thr_gated > bsc_pkg::FULL_SCALE_CODE) ?
                        bsc_pkg::FULL_SCALE_CODE : thr_gated;

   // exact floor of the scaled value through a reciprocal multiply
   assign product  = bsc_pkg::PRODUCT_W'(thr_clamped) *
                     bsc_pkg::PRODUCT_W'(bsc_pkg::SCALE_MULT);
   assign quotient = product >> bsc_pkg::SCALE_SHIFT;
   assign scaled   = quotient[bsc_pkg::DUTY_W-1:0];

   // ceiling clamp
   assign target = (scaled > ceiling) ? ceiling : scaled;

endmodule

// ----- hw/rtl/bsc_slew_limit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_slew_limit - duty slew limiter
// Moves the held duty toward the target by at most one step per item.
// ----------------------------------------------------------------------------
module bsc_slew_limit (
   input  logic [bsc_pkg::DUTY_W-1:0] held,
   input  logic [bsc_pkg::DUTY_W-1:0] target,
   input  logic [bsc_pkg::DUTY_W-1:0] step,
   output logic [bsc_pkg::DUTY_W-1:0] next_held
);

   logic [bsc_pkg::DUTY_W:0] held_up;
   logic [bsc_pkg::DUTY_W:0] target_up;

   // one extra bit so the sums never wrap
   assign held_up   = {1'b0, held} + {1'b0, step};
   assign target_up = {1'b0, target} + {1'b0, step};

   always_comb begin
      if ({1'b0, target} > held_up) begin
         next_held = held_up[bsc_pkg::DUTY_W-1:0];
      end else if (target_up < {1'b0, held}) begin
         next_held = held - step;
      end else begin
         next_held = target;
      end
   end

endmodule

// ----- hw/rtl/bsc_drive_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_drive_decode - sector to gate drive pattern
// One PWM top, one bottom switch per valid sector, else fault; off if disabled.
// ----------------------------------------------------------------------------
module bsc_drive_decode (
   input  logic [bsc_pkg::SECTOR_W-1:0] sector,
   input  logic                         motor_disable,
   output bsc_pkg::drive_type           drive
);

   always_comb begin
      drive             = '0;
      drive.sector_used = sector;
      if (motor_disable) begin
         // everything off, sector reported as off, no fault
         drive.sector_used = bsc_pkg::SECTOR_OFF;
      end else begin
         case (sector)
            bsc_pkg::SECTOR_A_HI_B_LO: begin
               drive.high_pwm_a = 1'b1;
               drive.low_on_b   = 1'b1;
            end
            bsc_pkg::SECTOR_A_HI_C_LO: begin
               drive.high_pwm_a = 1'b1;
               drive.low_on_c   = 1'b1;
            end
            bsc_pkg::SECTOR_B_HI_C_LO: begin
               drive.high_pwm_b = 1'b1;
               drive.low_on_c   = 1'b1;
            end
            bsc_pkg::SECTOR_B_HI_A_LO: begin
               drive.high_pwm_b = 1'b1;
               drive.low_on_a   = 1'b1;
            end
            bsc_pkg::SECTOR_C_HI_A_LO: begin
               drive.high_pwm_c = 1'b1;
               drive.low_on_a   = 1'b1;
            end
            bsc_pkg::SECTOR_C_HI_B_LO: begin
               drive.high_pwm_c = 1'b1;
               drive.low_on_b   = 1'b1;
            end
            default: begin
               drive.sector_fault = 1'b1;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/bldc_six_step_hall_commutator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldc_six_step_hall_commutator - six-step hall BLDC commutator
// Turns control ticks into a slew-limited duty and a six-step drive pattern.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one control tick per item: throttle sample, hall levels
//   and motor_disable. rsp_chan returns exactly one item per tick with the
//   duty, the six gate drive bits, the sector applied and a fault flag. The
//   user writes csr port registers (csr_wr_en, csr_index, csr_wdata) only while
//   no item is in flight, not enforced by the block; unknown indexes ignored.
// Timing:
//   Three register stages: input, target/sector, result. An accepted tick
//   passes through them in that order and is then offered on rsp_chan.
//   One item per cycle is sustained while rsp_chan is ready; the held
//   duty, read and rewritten in the last stage in the same cycle, sets it.
// Reset (synchronous, active high):
//   Pipeline emptied, registers back to their defaults, held duty to 500.
// Stall:
//   Each stage moves on its own ready, so while rsp_chan is stalled the
//   empty stages ahead of it still take new items; the result is held.
// ----------------------------------------------------------------------------
module bldc_six_step_hall_commutator (
   input  logic                            clock,
   input  logic                            reset,
   bsc_req_if.sink                         req_chan,
   bsc_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [bsc_pkg::THROTTLE_W-1:0] deadband_ff, deadband_in;
   logic [bsc_pkg::DUTY_W-1:0]     slew_ff, slew_in;
   logic [bsc_pkg::DUTY_W-1:0]     ceiling_ff, ceiling_in;
   logic [bsc_pkg::SECTOR_W-1:0]   manual_ff, manual_in;

   // input stage
   logic                           in_valid_ff, in_valid_in;
   logic [bsc_pkg::THROTTLE_W-1:0] in_throttle_ff, in_throttle_in;
   logic [bsc_pkg::HALL_W-1:0]     in_hall_ff, in_hall_in;
   logic                           in_disable_ff, in_disable_in;

   // middle stage
   logic                           mid_valid_ff, mid_valid_in;
   bsc_pkg::mid_type               mid_ff, mid_in;

   // result stage and held duty
   logic                           out_valid_ff, out_valid_in;
   logic [bsc_pkg::DUTY_W-1:0]     out_duty_ff, out_duty_in;
   bsc_pkg::drive_type             out_drive_ff, out_drive_in;
   logic [bsc_pkg::DUTY_W-1:0]     held_ff, held_in;

   // handshake
   logic out_ready, mid_ready, in_ready;
   logic req_fire, in_move, mid_move;

   // datapath
   logic [bsc_pkg::DUTY_W-1:0]   target;
   logic [bsc_pkg::SECTOR_W-1:0] sector_sel;
   logic [bsc_pkg::DUTY_W-1:0]   slew_next;
   bsc_pkg::drive_type           drive;

   // stage readiness, each stage frees when it is empty or moving on
   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign mid_ready      = !mid_valid_ff || out_ready;
   assign in_ready       = !in_valid_ff || mid_ready;
   assign req_chan.ready = in_ready;
   assign req_fire       = req_chan.valid && in_ready;
   assign in_move        = in_valid_ff && mid_ready;
   assign mid_move       = mid_valid_ff && out_ready;

   // configuration writes
   always_comb begin
      deadband_in = deadband_ff;
      slew_in     = slew_ff;
      ceiling_in  = ceiling_ff;
      manual_in   = manual_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bsc_pkg::CSR_DEADBAND:      deadband_in = csr_wdata[bsc_pkg::THROTTLE_W-1:0];
            bsc_pkg::CSR_SLEW_STEP:     slew_in     = csr_wdata[bsc_pkg::DUTY_W-1:0];
            bsc_pkg::CSR_DUTY_CEILING:  ceiling_in  = csr_wdata[bsc_pkg::DUTY_W-1:0];
            bsc_pkg::CSR_MANUAL_SECTOR: manual_in   = csr_wdata[bsc_pkg::SECTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage capture
   always_comb begin
      in_valid_in    = in_ready ? req_chan.valid : in_valid_ff;
      in_throttle_in = in_throttle_ff;
      in_hall_in     = in_hall_ff;
      in_disable_in  = in_disable_ff;
      if (req_fire) begin
         in_throttle_in = req_chan.throttle;
         in_hall_in     = {req_chan.hall_u, req_chan.hall_v, req_chan.hall_w};
         in_disable_in  = req_chan.motor_disable;
      end
   end

   // target duty and sector selection
   bsc_duty_target u_duty_target (
      .throttle (in_throttle_ff),
      .deadband (deadband_ff),
      .ceiling  (ceiling_ff),
      .target   (target)
   );

   assign sector_sel = (manual_ff != bsc_pkg::SECTOR_FROM_HALL) ?
                       manual_ff : bsc_pkg::HALL_SECTOR_TABLE[in_hall_ff];

   always_comb begin
      mid_valid_in = mid_ready ? in_valid_ff : mid_valid_ff;
      mid_in       = mid_ff;
      if (in_move) begin
         mid_in.target        = target;
         mid_in.sector        = sector_sel;
         mid_in.motor_disable = in_disable_ff;
      end
   end

   // slew limit against the held duty and drive decode
   bsc_slew_limit u_slew_limit (
      .held      (held_ff),
      .target    (mid_ff.target),
      .step      (slew_ff),
      .next_held (slew_next)
   );

   bsc_drive_decode u_drive_decode (
      .sector        (mid_ff.sector),
      .motor_disable (mid_ff.motor_disable),
      .drive         (drive)
   );

   always_comb begin
      out_valid_in = out_ready ? mid_valid_ff : out_valid_ff;
      out_duty_in  = out_duty_ff;
      out_drive_in = out_drive_ff;
      held_in      = held_ff;
      if (mid_move) begin
         out_drive_in = drive;
         if (mid_ff.motor_disable) begin
            out_duty_in = held_ff;
         end else begin
            out_duty_in = slew_next;
            held_in     = slew_next;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= bsc_pkg::DEADBAND_RST;
         slew_ff      <= bsc_pkg::SLEW_STEP_RST;
         ceiling_ff   <= bsc_pkg::DUTY_CEILING_RST;
         manual_ff    <= bsc_pkg::MANUAL_SECTOR_RST;
         held_ff      <= bsc_pkg::HELD_DUTY_RST;
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         deadband_ff  <= deadband_in;
         slew_ff      <= slew_in;
         ceiling_ff   <= ceiling_in;
         manual_ff    <= manual_in;
         held_ff      <= held_in;
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_throttle_ff <= in_throttle_in;
      in_hall_ff     <= in_hall_in;
      in_disable_ff  <= in_disable_in;
      mid_ff         <= mid_in;
      out_duty_ff    <= out_duty_in;
      out_drive_ff   <= out_drive_in;
   end

   // result channel
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.duty         = out_duty_ff;
   assign rsp_chan.high_pwm_a   = out_drive_ff.high_pwm_a;
   assign rsp_chan.high_pwm_b   = out_drive_ff.high_pwm_b;
   assign rsp_chan.high_pwm_c   = out_drive_ff.high_pwm_c;
   assign rsp_chan.low_on_a     = out_drive_ff.low_on_a;
   assign rsp_chan.low_on_b     = out_drive_ff.low_on_b;
   assign rsp_chan.low_on_c     = out_drive_ff.low_on_c;
   assign rsp_chan.sector_used  = out_drive_ff.sector_used;
   assign rsp_chan.sector_fault = out_drive_ff.sector_fault;

   // a faulted sector never drives a switch
   a_fault_drives_off: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.sector_fault |->
         !(rsp_chan.high_pwm_a || rsp_chan.high_pwm_b || rsp_chan.high_pwm_c ||
           rsp_chan.low_on_a || rsp_chan.low_on_b || rsp_chan.low_on_c))
      else $error("drive active with sector fault");

   // at most one top and one bottom switch, never both on one phase
   a_drive_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         $onehot0({rsp_chan.high_pwm_a, rsp_chan.high_pwm_b, rsp_chan.high_pwm_c}) &&
         $onehot0({rsp_chan.low_on_a, rsp_chan.low_on_b, rsp_chan.low_on_c}) &&
         !(rsp_chan.high_pwm_a && rsp_chan.low_on_a) &&
         !(rsp_chan.high_pwm_b && rsp_chan.low_on_b) &&
         !(rsp_chan.high_pwm_c && rsp_chan.low_on_c))
      else $error("conflicting gate drives");

   // held duty moves by no more than one slew step per cycle
   a_slew_bounded: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ((held_ff >= $past(held_ff)) ? ((held_ff - $past(held_ff)) <= $past(slew_ff))
                                      : (($past(held_ff) - held_ff) <= $past(slew_ff))))
      else $error("held duty exceeded slew step");

   // an empty result register leaves the pipeline open to new items
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with empty result stage");

endmodule
